[sv/plrc_pkg.sv]
// Shared types, constants and helper functions of the radix converter.
package plrc_pkg;

  // Width of the parse accumulator; the value field carries its low 32 bits.
  localparam int VALUE_BITS = 32;

  // Digit counts per output base and the shift register that holds the digits.
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int SH_W_A     = (OCT_DIGITS * 3 > HEX_DIGITS * 4) ? OCT_DIGITS * 3
                                                               : HEX_DIGITS * 4;
  localparam int SH_W       = (SH_W_A > VALUE_BITS) ? SH_W_A : VALUE_BITS;
  localparam int LD_BIN     = SH_W - VALUE_BITS;
  localparam int LD_OCT     = SH_W - OCT_DIGITS * 3;
  localparam int LD_HEX     = SH_W - HEX_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  // ASCII characters
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_B  = 8'h62;
  localparam logic [7:0] CHAR_X  = 8'h78;

  // Source radix codes
  localparam logic [1:0] RX_BIN = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_DEC = 2'd2;
  localparam logic [1:0] RX_HEX = 2'd3;

  // Output base codes (the reserved code formats as hex)
  localparam logic [1:0] BASE_BIN  = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_HEX  = 2'd2;
  localparam logic [1:0] BASE_RSVD = 2'd3;

  // Which part of the literal the incoming item belongs to
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ZERO  = 2'd1,
    MODE_BODY  = 2'd2
  } mode_e;

  // Source of the next output character
  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_PFX   = 2'd1,
    SEL_DIGIT = 2'd2
  } sel_e;

  typedef struct packed {
    logic  accept;     // input item taken this cycle
    mode_e mode;
    logic  load_emit;  // final item: capture value, start emission
    logic  shift;      // drop the top digit
    logic  out_load;   // write the output register
    sel_e  out_sel;
    logic  out_last;
  } plrc_cmd_t;

  typedef struct packed {
    logic ch_is_zero;
    logic skip_done;   // top digit nonzero or only one digit left
    logic last_digit;
    logic base_oct;
  } plrc_status_t;

  // Value of a hex digit character, zero for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = c[3:0];
    end else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF)) begin
      r = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

  // Fold one character into the accumulator, wrapping
  function automatic logic [VALUE_BITS-1:0] absorb(input logic [VALUE_BITS-1:0] acc,
                                                   input logic [7:0] c,
                                                   input logic [1:0] rad);
    logic [VALUE_BITS-1:0] d;
    logic [VALUE_BITS-1:0] r;
    d = VALUE_BITS'(c) - VALUE_BITS'(CHAR_0);
    case (rad)
      RX_BIN:  r = (acc << 1) + d;
      RX_OCT:  r = (acc << 3) + d;
      RX_DEC:  r = (acc << 3) + (acc << 1) + d;
      default: r = (acc << 4) + VALUE_BITS'(hex_val(c));
    endcase
    return r;
  endfunction

  // Upper-case character of one digit
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d > 4'd9) begin
      r = CHAR_UA + {4'd0, d} - 8'd10;
    end else begin
      r = CHAR_0 + {4'd0, d};
    end
    return r;
  endfunction

endpackage

[sv/plrc_if.sv]
// Valid/ready channel interfaces: literal input, text output, configuration.
interface plrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface plrc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [31:0] value;
  logic [1:0]  src_radix;
  logic        out_last;
  modport source (output valid, out_char, value, src_radix, out_last, input ready);
  modport sink (input valid, out_char, value, src_radix, out_last, output ready);
endinterface

interface plrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/plrc_ctrl.sv]
// Controller: parse phase tracking and output text sequencing.
module plrc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  plrc_pkg::plrc_status_t status_i,
  output plrc_pkg::plrc_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_START = 7'b0000001,
    ST_ZERO  = 7'b0000010,
    ST_BODY  = 7'b0000100,
    ST_SKIP  = 7'b0001000,
    ST_PFX0  = 7'b0010000,
    ST_PFX1  = 7'b0100000,
    ST_DIGIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_START) || (state_q == ST_ZERO) || (state_q == ST_BODY);
  assign accept     = in_ready_o && in_valid_i;

  // Next state and datapath commands
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.accept      = accept;
    cmd_o.mode        = plrc_pkg::MODE_BODY;
    cmd_o.out_sel     = plrc_pkg::SEL_ZERO;
    case (state_q)
      ST_START: begin
        cmd_o.mode = plrc_pkg::MODE_START;
        if (accept) begin
          state_d = status_i.ch_is_zero ? ST_ZERO : ST_BODY;
        end
      end
      ST_ZERO: begin
        cmd_o.mode = plrc_pkg::MODE_ZERO;
        if (accept) begin
          state_d = ST_BODY;
        end
      end
      ST_BODY: begin
        cmd_o.mode = plrc_pkg::MODE_BODY;
      end
      ST_SKIP: begin
        if (status_i.skip_done) begin
          state_d = ST_PFX0;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      ST_PFX0: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = plrc_pkg::SEL_ZERO;
          state_d        = status_i.base_oct ? ST_DIGIT : ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = plrc_pkg::SEL_PFX;
          state_d        = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = plrc_pkg::SEL_DIGIT;
          cmd_o.shift    = 1'b1;
          cmd_o.out_last = status_i.last_digit;
          if (status_i.last_digit) begin
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_START;
    endcase
    // a final item ends the literal whatever phase it came in
    if (accept && in_last_i) begin
      cmd_o.load_emit = 1'b1;
      state_d         = ST_SKIP;
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // never overwrite a character the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while stalled");
  // a final item always starts emission
  a_last_to_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> (state_q == ST_SKIP))
    else $error("final item did not start emission");
  // no input is taken while text is pending emission
  a_no_input_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_PFX0 || state_q == ST_PFX1 ||
     state_q == ST_DIGIT) |-> !in_ready_o)
    else $error("input accepted during emission");
`endif

endmodule

[sv/plrc_dp.sv]
// Datapath: accumulator, digit shift register, configuration and output register.
module plrc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_data_i,
  input  logic [7:0]            ch_i,
  input  plrc_pkg::plrc_cmd_t    cmd_i,
  output plrc_pkg::plrc_status_t status_o,
  output logic [7:0]            out_char_o,
  output logic [31:0]           value_o,
  output logic [1:0]            src_radix_o,
  output logic                  out_last_o
);

  logic [1:0]                      base_q;
  logic [plrc_pkg::VALUE_BITS-1:0] acc_q, acc_d;
  logic [1:0]                      rad_q, rad_d;
  logic [plrc_pkg::VALUE_BITS-1:0] nxt_acc;
  logic [1:0]                      nxt_rad;
  logic [plrc_pkg::SH_W-1:0]       sh_q, sh_d;
  logic [plrc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [31:0]                     val_q, val_d;
  logic [1:0]                      vrad_q, vrad_d;
  logic [3:0]                      top_dig;
  logic                            base_bin, base_oct;
  logic [7:0]                      out_char_q;
  logic [31:0]                     out_val_q;
  logic [1:0]                      out_rad_q;
  logic                            out_last_q;
  logic [7:0]                      char_sel;

  assign base_bin = (base_q == plrc_pkg::BASE_BIN);
  assign base_oct = (base_q == plrc_pkg::BASE_OCT);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= plrc_pkg::BASE_BIN;
    end else if (cfg_we_i) begin
      base_q <= cfg_data_i;
    end
  end

  // Accumulate the incoming character
  always_comb begin
    nxt_acc = acc_q;
    nxt_rad = rad_q;
    case (cmd_i.mode)
      plrc_pkg::MODE_START: begin
        if (ch_i == plrc_pkg::CHAR_0) begin
          nxt_acc = '0;
          nxt_rad = plrc_pkg::RX_OCT;
        end else begin
          nxt_acc = plrc_pkg::absorb('0, ch_i, plrc_pkg::RX_DEC);
          nxt_rad = plrc_pkg::RX_DEC;
        end
      end
      plrc_pkg::MODE_ZERO: begin
        if (ch_i == plrc_pkg::CHAR_B) begin
          nxt_rad = plrc_pkg::RX_BIN;
        end else if (ch_i == plrc_pkg::CHAR_X) begin
          nxt_rad = plrc_pkg::RX_HEX;
        end else begin
          nxt_acc = plrc_pkg::absorb(acc_q, ch_i, rad_q);
        end
      end
      default: nxt_acc = plrc_pkg::absorb(acc_q, ch_i, rad_q);
    endcase
  end

  // Top digit of the shift register in the output base
  always_comb begin
    if (base_bin) begin
      top_dig = {3'd0, sh_q[plrc_pkg::SH_W-1]};
    end else if (base_oct) begin
      top_dig = {1'b0, sh_q[plrc_pkg::SH_W-1 -: 3]};
    end else begin
      top_dig = sh_q[plrc_pkg::SH_W-1 -: 4];
    end
  end

  // Parse state, capture on the final item, digit stepping
  always_comb begin
    acc_d  = acc_q;
    rad_d  = rad_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    vrad_d = vrad_q;
    if (cmd_i.load_emit) begin
      acc_d  = '0;
      rad_d  = plrc_pkg::RX_BIN;
      val_d  = 32'(nxt_acc);
      vrad_d = nxt_rad;
      if (base_bin) begin
        sh_d  = plrc_pkg::SH_W'(nxt_acc) << plrc_pkg::LD_BIN;
        cnt_d = plrc_pkg::CNT_W'(plrc_pkg::VALUE_BITS);
      end else if (base_oct) begin
        sh_d  = plrc_pkg::SH_W'(nxt_acc) << plrc_pkg::LD_OCT;
        cnt_d = plrc_pkg::CNT_W'(plrc_pkg::OCT_DIGITS);
      end else begin
        sh_d  = plrc_pkg::SH_W'(nxt_acc) << plrc_pkg::LD_HEX;
        cnt_d = plrc_pkg::CNT_W'(plrc_pkg::HEX_DIGITS);
      end
    end else if (cmd_i.accept) begin
      acc_d = nxt_acc;
      rad_d = nxt_rad;
    end else if (cmd_i.shift) begin
      cnt_d = cnt_q - plrc_pkg::CNT_W'(1);
      if (base_bin) begin
        sh_d = sh_q << 1;
      end else if (base_oct) begin
        sh_d = sh_q << 3;
      end else begin
        sh_d = sh_q << 4;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rad_q <= plrc_pkg::RX_BIN;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      rad_q <= rad_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    val_q  <= val_d;
    vrad_q <= vrad_d;
  end

  // Output character select and register
  always_comb begin
    case (cmd_i.out_sel)
      plrc_pkg::SEL_ZERO:  char_sel = plrc_pkg::CHAR_0;
      plrc_pkg::SEL_PFX:   char_sel = base_bin ? plrc_pkg::CHAR_B : plrc_pkg::CHAR_X;
      plrc_pkg::SEL_DIGIT: char_sel = plrc_pkg::digit_char(top_dig);
      default:             char_sel = plrc_pkg::CHAR_0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q <= char_sel;
      out_val_q  <= val_q;
      out_rad_q  <= vrad_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_char_o  = out_char_q;
  assign value_o     = out_val_q;
  assign src_radix_o = out_rad_q;
  assign out_last_o  = out_last_q;

  assign status_o.ch_is_zero = (ch_i == plrc_pkg::CHAR_0);
  assign status_o.last_digit = (cnt_q == plrc_pkg::CNT_W'(1));
  assign status_o.skip_done  = (cnt_q == plrc_pkg::CNT_W'(1)) || (top_dig != 4'd0);
  assign status_o.base_oct   = base_oct;

`ifndef NO_ASSERTIONS
  // digit stepping never runs past the last digit
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (cnt_q != '0))
    else $error("digit shift with no digits left");
`endif

endmodule

[sv/prefixed_literal_radix_converter.sv]
// Top level: converts a prefixed ASCII number literal to text in another base.
//
// in_i carries the literal one character per item (ch) with last set on the
// final character. A "0b" prefix selects binary, "0x" hex, a lone leading
// '0' octal, anything else decimal; digits wrap into a 32-bit value.
// cfg_i writes the output base (0 binary, 1 octal, 2 hex); it is always
// ready. The user must see that it is written only while the block is
// idle; the block itself does not enforce this. out_o returns the text
// most significant digit first with its prefix ("0b", "0", "0x", hex in
// upper case), one character per item, each with the parsed value and
// detected source radix; out_last flags the final one.
// Rate: characters before the final one are taken one per cycle. After the
// final character the digit shift register drops leading zeros at one digit
// a cycle, then leaves the skip and emits prefix and digits one per cycle
// while the receiver takes them. The next literal is accepted as soon as
// the last character sits in the output register. A stalled receiver
// holds the output register and pauses the sequence. Reset clears the
// parser, empties the output and selects binary.
module prefixed_literal_radix_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  plrc_in_if.sink     in_i,
  plrc_out_if.source  out_o,
  plrc_cfg_if.sink    cfg_i
);

  plrc_pkg::plrc_cmd_t    cmd;
  plrc_pkg::plrc_status_t status;

  assign cfg_i.ready = 1'b1;

  plrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .ch_i        (in_i.ch),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_char_o  (out_o.out_char),
    .value_o     (out_o.value),
    .src_radix_o (out_o.src_radix),
    .out_last_o  (out_o.out_last)
  );

endmodule
